### rtl/lfht_pkg.sv
// ----------------------------------------------------------------------------
// lfht_pkg
// Shared types and codes for the lowest-free handle table.
// ----------------------------------------------------------------------------
package lfht_pkg;

	localparam int HANDLE_W  = 6;
	localparam int PAYLOAD_W = 32;

	// request operation codes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;

	// response status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_CORRUPT = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	// command kinds after front-end decode
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP  = 2'd2;
	localparam logic [1:0] KIND_BAD     = 2'd3;

	// command queue between front end and engine
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// free-slot search group size
	localparam int GROUP_W  = 8;
	localparam int GROUP_IW = $clog2(GROUP_W);

	typedef struct packed {
		logic [1:0]           operation;
		logic [HANDLE_W-1:0]  handle;
		logic [PAYLOAD_W-1:0] payload;
	} req_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [HANDLE_W-1:0]  handle_out;
		logic                 found;
		logic [PAYLOAD_W-1:0] payload_out;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [HANDLE_W-1:0]  handle;
		logic [PAYLOAD_W-1:0] payload;
	} cmd_t;

	// queue status toward the front end and the engine
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

### rtl/lfht_front.sv
// ----------------------------------------------------------------------------
// lfht_front
// Request intake: decodes the operation into a command and pushes it.
// ----------------------------------------------------------------------------
module lfht_front
	import lfht_pkg::*;
(
	input  logic        req_valid,
	output logic        req_stall,
	input  req_item_t   req,
	input  queue_stat_t q_stat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [1:0] kind;

	always_comb begin
		unique case (req.operation)
			OP_ALLOC:   kind = KIND_ALLOC;
			OP_RELEASE: kind = KIND_RELEASE;
			OP_LOOKUP:  kind = KIND_LOOKUP;
			default:    kind = KIND_BAD;
		endcase
	end

	assign req_stall = q_stat.full;
	assign push      = req_valid && !q_stat.full;

	// payload only matters for allocate; keep it zero otherwise
	assign push_cmd.kind    = kind;
	assign push_cmd.handle  = req.handle;
	assign push_cmd.payload = (kind == KIND_ALLOC) ? req.payload : '0;

endmodule

### rtl/lfht_queue.sv
// ----------------------------------------------------------------------------
// lfht_queue
// Short command FIFO between the front end and the engine.
// ----------------------------------------------------------------------------
module lfht_queue
	import lfht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cmd_t        push_cmd,
	input  logic        pop,
	output cmd_t        pop_cmd,
	output queue_stat_t q_stat
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign q_stat.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/lfht_engine.sv
// ----------------------------------------------------------------------------
// lfht_engine
// Executes commands against the slot table and drives the response register.
// ----------------------------------------------------------------------------
module lfht_engine
	import lfht_pkg::*;
#(
	parameter int SLOTS        = 64,
	parameter int PAYLOAD_BITS = 32,
	localparam int HW          = $clog2(SLOTS + 1)
)(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_stat_t   q_stat,
	input  cmd_t          q_cmd,
	output logic          q_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsp_item_t     rsp,
	output logic [HW-1:0] mon_high_water,
	output logic [HW-1:0] mon_first_free
);

	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW   = (HW > HANDLE_W) ? HW : HANDLE_W;
	localparam int NG   = (SLOTS + GROUP_W - 1) / GROUP_W;
	localparam int PADW = NG * GROUP_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_SCAN1 = 2'd2;
	localparam logic [1:0] S_SCAN2 = 2'd3;

	logic [1:0]              state_q;
	logic [SLOTS-1:0]        live_q;
	logic [HW-1:0]           hw_q;
	logic [HW-1:0]           ff_q;
	logic [HW-1:0]           pos_q;
	logic [PAYLOAD_BITS-1:0] mem [SLOTS];
	logic [PAYLOAD_BITS-1:0] rd_q;
	logic [NG-1:0]           grp_any_q;
	logic [GROUP_IW-1:0]     grp_low_q [NG];
	rsp_item_t               res_q;
	logic                    res_valid_q;

	logic                    out_free;
	logic                    hole;
	logic                    full;
	logic                    h_ok;
	logic                    h_below_ff;
	logic                    hit;
	logic [IW-1:0]           h_idx;
	logic [IW-1:0]           ff_idx;
	logic [IW-1:0]           hw_idx;
	logic                    res_set;
	rsp_item_t               res_d;
	logic                    mem_we;
	logic [IW-1:0]           mem_wa;
	logic [PADW-1:0]         live_pad;
	logic [NG-1:0]           grp_any;
	logic [GROUP_IW-1:0]     grp_low [NG];
	logic [HW-1:0]           scan_ff;

	assign out_free   = !res_valid_q || !rsp_stall;
	assign q_pop      = (state_q == S_IDLE) && !q_stat.empty && out_free;
	assign hole       = ff_q < hw_q;
	assign full       = (hw_q == HW'(SLOTS));
	assign h_ok       = CW'(q_cmd.handle) < CW'(hw_q);
	assign h_below_ff = CW'(q_cmd.handle) < CW'(ff_q);
	assign h_idx      = IW'(q_cmd.handle);
	assign ff_idx     = IW'(ff_q);
	assign hw_idx     = IW'(hw_q);
	assign hit        = h_ok && live_q[h_idx];

	// response and store write for the command being popped
	always_comb begin
		res_set = 1'b0;
		res_d   = '0;
		mem_we  = 1'b0;
		mem_wa  = ff_idx;
		if (q_pop) begin
			res_d.status = STAT_INVALID;
			unique case (q_cmd.kind)
				KIND_ALLOC: begin
					res_set = 1'b1;
					if (!hole) begin
						if (full) begin
							res_d.status = STAT_FULL;
						end else begin
							mem_we           = 1'b1;
							mem_wa           = hw_idx;
							res_d.status     = STAT_OK;
							res_d.handle_out = HANDLE_W'(hw_q);
						end
					end else if (live_q[ff_idx]) begin
						res_d.status = STAT_CORRUPT;
					end else begin
						mem_we           = 1'b1;
						res_d.status     = STAT_OK;
						res_d.handle_out = HANDLE_W'(ff_q);
					end
				end
				KIND_RELEASE: begin
					res_set      = 1'b1;
					res_d.status = h_ok ? STAT_OK : STAT_INVALID;
				end
				KIND_LOOKUP: begin
					// a hit answers from the registered store read next cycle
					res_set = !hit;
				end
				default: begin
					res_set = 1'b1;
				end
			endcase
		end else if (state_q == S_READ) begin
			res_set           = 1'b1;
			res_d.status      = STAT_OK;
			res_d.found       = 1'b1;
			res_d.payload_out = PAYLOAD_W'(rd_q);
		end
	end

	// first search stage: lowest free slot inside each group of eight,
	// above the reused slot and below the high-water mark
	assign live_pad = PADW'(live_q);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = 1'b0;
			grp_low[g] = '0;
			for (int j = GROUP_W - 1; j >= 0; j--) begin
				if (!live_pad[g * GROUP_W + j] && (g * GROUP_W + j > int'(pos_q))
						&& (g * GROUP_W + j < int'(hw_q))) begin
					grp_any[g] = 1'b1;
					grp_low[g] = GROUP_IW'(j);
				end
			end
		end
	end

	// second search stage: lowest group with a free slot
	always_comb begin
		scan_ff = hw_q;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				scan_ff = HW'(g * GROUP_W + int'(grp_low_q[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= PAYLOAD_BITS'(q_cmd.payload);
		end
		if (q_pop) begin
			rd_q <= mem[h_idx];
		end
		if (state_q == S_SCAN1) begin
			grp_any_q <= grp_any;
			for (int g = 0; g < NG; g++) begin
				grp_low_q[g] <= grp_low[g];
			end
		end
		if (res_set) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			hw_q        <= '0;
			ff_q        <= '0;
			pos_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_cmd.kind)
							KIND_ALLOC: begin
								if (!hole && !full) begin
									live_q[hw_idx] <= 1'b1;
									hw_q           <= hw_q + 1'b1;
									ff_q           <= hw_q + 1'b1;
								end else if (hole && !live_q[ff_idx]) begin
									live_q[ff_idx] <= 1'b1;
									pos_q          <= ff_q;
									state_q        <= S_SCAN1;
								end
							end
							KIND_RELEASE: begin
								if (h_ok) begin
									live_q[h_idx] <= 1'b0;
									if (h_below_ff) begin
										ff_q <= HW'(q_cmd.handle);
									end
								end
							end
							KIND_LOOKUP: begin
								if (hit) begin
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ:  state_q <= S_IDLE;
				S_SCAN1: state_q <= S_SCAN2;
				S_SCAN2: begin
					ff_q    <= scan_ff;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid      = res_valid_q;
	assign rsp            = res_q;
	assign mon_high_water = hw_q;
	assign mon_first_free = ff_q;

endmodule

### rtl/lowest_free_handle_table.sv
// Path: command queue, then engine response register; a lookup hit adds the store read.
// Throughput: 1 item per cycle for release, miss, full and extend-allocate while the
//   response is not stalled; a lookup hit (registered store read) or an allocate that
//   reuses a hole (two-stage free-slot search over the in-use map) stalls the queue.
// Reset: asynchronous, clears the in-use map, high-water mark, free pointer,
//   command queue and response valid flag; payload storage is not cleared.
// ----------------------------------------------------------------------------
// lowest_free_handle_table
// Handle allocator that hands out the lowest free slot, with release and lookup.
// ----------------------------------------------------------------------------
module lowest_free_handle_table
	import lfht_pkg::*;
#(
	parameter int SLOTS        = 64,
	parameter int PAYLOAD_BITS = 32
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int HW = $clog2(SLOTS + 1);

	queue_stat_t   q_stat;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          pop_cmd;
	logic [HW-1:0] mon_high_water;
	logic [HW-1:0] mon_first_free;

	lfht_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	lfht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	lfht_engine #(
		.SLOTS        (SLOTS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.q_cmd          (pop_cmd),
		.q_pop          (pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.mon_high_water (mon_high_water),
		.mon_first_free (mon_first_free)
	);

	// free pointer never runs past the high-water mark
	assert property (@(posedge clk) disable iff (!arst_n)
		mon_first_free <= mon_high_water)
		else $error("first free pointer above high-water mark");

	// high-water mark only grows
	assert property (@(posedge clk) disable iff (!arst_n)
		mon_high_water >= $past(mon_high_water))
		else $error("high-water mark decreased");

	// engine only pops a queue that holds a command
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty command queue");

	// an allocate that extends the table raises the high-water mark by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_cmd.kind == KIND_ALLOC && mon_first_free >= mon_high_water
			&& mon_high_water != HW'(SLOTS))
		|=> mon_high_water == $past(mon_high_water) + 1'b1)
		else $error("extend allocate did not advance high-water mark");

endmodule
